// ===== hdl/reduce_along_dimension_macros.svh =====
// ---------------------------------------------------------------------------
// reduce_along_dimension assertion macros
// concurrent checks that vanish when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef REDUCE_ALONG_DIMENSION_MACROS_SVH
`define REDUCE_ALONG_DIMENSION_MACROS_SVH

`ifndef SYNTHESIS

// plain property, checked at every edge outside reset
`define RAD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define RAD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RAD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define RAD_ASSERT(lbl, clk, rst_n, prop, msg)
`define RAD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define RAD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hdl/rad_pkg.sv =====
// ---------------------------------------------------------------------------
// rad_pkg
// shared constants for the streaming reduction block
// ---------------------------------------------------------------------------
`default_nettype none

package rad_pkg;

	// default sizes
	localparam int DATA_WIDTH_DEF  = 32;
	localparam int INNER_DEPTH_DEF = 256;
	localparam int REDUCE_MAX_DEF  = 65536;

	// port widths fixed by the word format
	localparam int FIELD_W    = 32;
	localparam int CFG_DATA_W = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int OP_W       = 2;

	// raw register field widths
	localparam int REDUCE_FIELD_W = 17;
	localparam int INNER_FIELD_W  = 9;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_OP     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REDUCE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INNER  = 2'd2;

	// operation codes, the spare code acts as sum
	localparam logic [OP_W-1:0] OP_SUM    = 2'd0;
	localparam logic [OP_W-1:0] OP_MAX    = 2'd1;
	localparam logic [OP_W-1:0] OP_ARGMAX = 2'd2;

endpackage

`default_nettype wire

// ===== hdl/rad_slot_ram.sv =====
// ---------------------------------------------------------------------------
// rad_slot_ram
// per-slot accumulator store, registered read with last-write forwarding
// ---------------------------------------------------------------------------
`default_nettype none

module rad_slot_ram #(
	parameter int DEPTH  = 256,
	parameter int ADDR_W = 8,
	parameter int WORD_W = 48
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WORD_W-1:0] rd_data,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WORD_W-1:0] wr_data
);

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rd_data_q;
	logic [ADDR_W-1:0] rd_addr_q;
	logic              lw_valid_q;
	logic [ADDR_W-1:0] lw_addr_q;
	logic [WORD_W-1:0] lw_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
			rd_addr_q <= rd_addr;
		end
	end

	// last write, newer than anything the read may have missed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_valid_q <= 1'b0;
		end else if (wr_en) begin
			lw_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			lw_addr_q <= wr_addr;
			lw_data_q <= wr_data;
		end
	end

	assign rd_data = (lw_valid_q && (lw_addr_q == rd_addr_q)) ? lw_data_q : rd_data_q;

endmodule

`default_nettype wire

// ===== hdl/reduce_along_dimension.sv =====
// ---------------------------------------------------------------------------
// reduce_along_dimension
// streaming sum, max or argmax of an integer tensor along one dimension
// ---------------------------------------------------------------------------
// Elements arrive in memory order (outer slice, reduced position, inner
// position). One accumulator and one best index per inner position live in a
// slot memory. The block takes one word per clock when the result side keeps
// up; a result is loaded into the output register when the update stage that
// holds its last element moves on, and is offered from there. The figure of one
// word per cycle is set by the
// read-modify-write of the slot memory: the read is issued as the word is
// taken, the update runs in the next cycle and writes back, and the freshest
// written slot is forwarded to cover back-to-back hits on one slot. The
// memory needs no clearing pass: a slot is always overwritten at reduced
// position zero, whatever it held. Any configuration write restarts the
// inner and reduced position counters, so the next word opens a new slice.
// ---------------------------------------------------------------------------
`default_nettype none

`include "reduce_along_dimension_macros.svh"

module reduce_along_dimension #(
	parameter int DATA_WIDTH  = rad_pkg::DATA_WIDTH_DEF,
	parameter int INNER_DEPTH = rad_pkg::INNER_DEPTH_DEF,
	parameter int REDUCE_MAX  = rad_pkg::REDUCE_MAX_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// configuration
	input  wire logic                               cfg_we,
	input  wire logic [rad_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [rad_pkg::CFG_DATA_W-1:0]     cfg_data,
	// element stream
	input  wire logic                               element_valid,
	output logic                                    element_ready,
	input  wire logic signed [rad_pkg::FIELD_W-1:0] element_value,
	// result stream
	output logic                                    result_valid,
	input  wire logic                               result_ready,
	output logic signed [rad_pkg::FIELD_W-1:0]      result_value,
	output logic                                    slice_done
);

	import rad_pkg::*;

	localparam int SLOT_W = (INNER_DEPTH > 1) ? $clog2(INNER_DEPTH) : 1;
	localparam int IC_W   = $clog2(INNER_DEPTH + 1);
	localparam int IDX_W  = $clog2(REDUCE_MAX);
	localparam int CNT_W  = $clog2(REDUCE_MAX + 1);
	localparam int WORD_W = DATA_WIDTH + IDX_W;

	// configuration registers
	logic [OP_W-1:0]  reduce_op_q;
	logic [CNT_W-1:0] reduce_count_q;
	logic [IC_W-1:0]  inner_count_q;

	// position counters
	logic [SLOT_W-1:0] inner_pos_q;
	logic [IDX_W-1:0]  red_pos_q;

	// update stage
	logic                  valid_s1;
	logic [DATA_WIDTH-1:0] elem_s1;
	logic [SLOT_W-1:0]     slot_s1;
	logic [IDX_W-1:0]      rpos_s1;
	logic                  first_s1;
	logic                  emit_s1;
	logic                  done_s1;

	// result register
	logic                      result_valid_q;
	logic signed [FIELD_W-1:0] result_value_q;
	logic                      slice_done_q;

	logic                  in_take;
	logic                  adv_s1;
	logic                  last_inner;
	logic                  last_red;
	logic [2*FIELD_W-1:0]  elem_wide;
	logic [WORD_W-1:0]     old_word;
	logic [DATA_WIDTH-1:0] old_acc;
	logic [IDX_W-1:0]      old_best;
	logic [DATA_WIDTH-1:0] new_acc;
	logic [IDX_W-1:0]      new_best;
	logic signed [63:0]    acc_ext;
	logic [FIELD_W-1:0]    new_result;
	logic [REDUCE_FIELD_W-1:0] cfg_red_raw;
	logic [INNER_FIELD_W-1:0]  cfg_inner_raw;
	logic [CNT_W-1:0]      cfg_red_sat;
	logic [IC_W-1:0]       cfg_inner_sat;

	// ---- handshake ----
	// the update stage moves on unless its result finds the output register full and not taken
	assign adv_s1        = valid_s1 && (!emit_s1 || !result_valid_q || result_ready);
	assign element_ready = !valid_s1 || adv_s1;
	assign in_take       = element_valid && element_ready;

	// ---- configuration, saturated into range ----
	assign cfg_red_raw   = cfg_data[REDUCE_FIELD_W-1:0];
	assign cfg_inner_raw = cfg_data[INNER_FIELD_W-1:0];

	always_comb begin
		if (cfg_red_raw == '0) begin
			cfg_red_sat = CNT_W'(1);
		end else if (32'(cfg_red_raw) > 32'(REDUCE_MAX)) begin
			cfg_red_sat = CNT_W'(REDUCE_MAX);
		end else begin
			cfg_red_sat = CNT_W'(cfg_red_raw);
		end
		if (cfg_inner_raw == '0) begin
			cfg_inner_sat = IC_W'(1);
		end else if (32'(cfg_inner_raw) > 32'(INNER_DEPTH)) begin
			cfg_inner_sat = IC_W'(INNER_DEPTH);
		end else begin
			cfg_inner_sat = IC_W'(cfg_inner_raw);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reduce_op_q    <= OP_SUM;
			reduce_count_q <= CNT_W'(1);
			inner_count_q  <= IC_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OP:     reduce_op_q    <= cfg_data[OP_W-1:0];
				REG_REDUCE: reduce_count_q <= cfg_red_sat;
				REG_INNER:  inner_count_q  <= cfg_inner_sat;
				default:    ;
			endcase
		end
	end

	// ---- position counters, stepped per word taken ----
	assign last_inner = (32'(inner_pos_q) + 32'd1) >= 32'(inner_count_q);
	assign last_red   = (32'(red_pos_q) + 32'd1) >= 32'(reduce_count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_pos_q <= '0;
			red_pos_q   <= '0;
		end else if (cfg_we) begin
			// any write, also beyond the list, restarts the slice
			inner_pos_q <= '0;
			red_pos_q   <= '0;
		end else if (in_take) begin
			if (last_inner) begin
				inner_pos_q <= '0;
				red_pos_q   <= last_red ? '0 : red_pos_q + IDX_W'(1);
			end else begin
				inner_pos_q <= inner_pos_q + SLOT_W'(1);
			end
		end
	end

	// ---- update stage registers ----
	assign elem_wide = {{FIELD_W{1'b0}}, element_value};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (element_ready) begin
			valid_s1 <= element_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			elem_s1  <= elem_wide[DATA_WIDTH-1:0];
			slot_s1  <= inner_pos_q;
			rpos_s1  <= red_pos_q;
			first_s1 <= (red_pos_q == '0);
			emit_s1  <= last_red;
			done_s1  <= last_inner;
		end
	end

	// ---- slot memory ----
	rad_slot_ram #(
		.DEPTH  (INNER_DEPTH),
		.ADDR_W (SLOT_W),
		.WORD_W (WORD_W)
	) u_slot_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_take),
		.rd_addr (inner_pos_q),
		.rd_data (old_word),
		.wr_en   (adv_s1),
		.wr_addr (slot_s1),
		.wr_data ({new_best, new_acc})
	);

	assign old_acc  = old_word[DATA_WIDTH-1:0];
	assign old_best = old_word[WORD_W-1:DATA_WIDTH];

	// ---- combine ----
	always_comb begin
		new_acc  = old_acc;
		new_best = old_best;
		if (first_s1) begin
			new_acc  = elem_s1;
			new_best = '0;
		end else begin
			unique case (reduce_op_q)
				OP_MAX, OP_ARGMAX: begin
					// only a strictly greater value replaces, keeping the first maximum
					if ($signed(elem_s1) > $signed(old_acc)) begin
						new_acc  = elem_s1;
						new_best = rpos_s1;
					end
				end
				default: begin
					new_acc = old_acc + elem_s1;
				end
			endcase
		end
	end

	assign acc_ext    = 64'(signed'(new_acc));
	assign new_result = (reduce_op_q == OP_ARGMAX) ? FIELD_W'(new_best) : acc_ext[FIELD_W-1:0];

	// ---- result register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv_s1 && emit_s1) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit_s1) begin
			result_value_q <= signed'(new_result);
			slice_done_q   <= done_s1;
		end
	end

	assign result_valid = result_valid_q;
	assign result_value = result_value_q;
	assign slice_done   = slice_done_q;

	// ---- checks ----
	`RAD_ASSERT(a_inner_in_range, clk, arst_n,
		32'(inner_pos_q) < 32'(inner_count_q), "inner position beyond inner count")
	`RAD_ASSERT(a_red_in_range, clk, arst_n,
		32'(red_pos_q) < 32'(reduce_count_q), "reduced position beyond reduce count")
	`RAD_ASSERT_IMP(a_stall_cause, clk, arst_n, !element_ready,
		valid_s1 && emit_s1 && result_valid_q && !result_ready,
		"element side stalled without a blocked result")
	`RAD_ASSERT_NXT(a_stage_holds, clk, arst_n, valid_s1 && !adv_s1,
		valid_s1 && $stable(slot_s1) && $stable(elem_s1), "held update stage lost its word")

endmodule

`default_nettype wire

// ===== sim/tb_reduce_along_dimension.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_reduce_along_dimension
// self-checking bench for the streaming sum, max and argmax reduction
// ---------------------------------------------------------------------------
// A queue of pending words feeds a driver that offers them in random bursts.
// Every word taken by the block is folded into a local model of the slot
// memory, and any result it completes is queued. A monitor compares each
// result taken from the block with the oldest queued one. Settings are
// changed only once the block has gone quiet. The run covers a short
// directed part, a series of random settings, the widest inner dimension,
// a receiver hold-off that backs the block up, and a saturated reduce count.
// ---------------------------------------------------------------------------

module tb_reduce_along_dimension;

	import rad_pkg::*;

	// register index past the end of the list, only restarts the counters
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	// spare operation code, behaves as sum
	localparam logic [OP_W-1:0]      OP_SPARE  = 2'd3;

	localparam int HALF_PERIOD  = 4;
	localparam int QUIET_CYCLES = 8;

	typedef logic signed [FIELD_W-1:0] word_t;

	typedef struct {
		word_t value;
		logic  done;
	} result_word_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// block inputs, known from time zero
	logic                  cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;
	logic                  element_valid = 1'b0;
	word_t                 element_value = '0;
	logic                  result_ready  = 1'b0;

	// block outputs
	logic  element_ready;
	logic  result_valid;
	word_t result_value;
	logic  slice_done;

	// stimulus and expected results
	word_t        pending_words[$];
	result_word_t expected_results[$];
	int           mismatches = 0;
	logic         took_word  = 1'b0;

	// sender burst state
	int burst_left = 0;
	int gap_left   = 0;

	// receiver stall state, the hold-off request comes from the sequence
	int   hold_off_request = 0;
	int   hold_off_left    = 0;
	int   stretch_left     = 0;
	logic stretch_ready    = 1'b0;

	// local copy of the block's state and settings
	word_t              slot_total[INNER_DEPTH_DEF];
	logic [15:0]        slot_best[INNER_DEPTH_DEF];
	int unsigned        inner_pos   = 0;
	int unsigned        reduced_pos = 0;
	logic [OP_W-1:0]    op_code     = OP_SUM;
	int unsigned        reduce_len  = 1;
	int unsigned        inner_len   = 1;

	int random_words = 0;

	reduce_along_dimension u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.element_valid (element_valid),
		.element_ready (element_ready),
		.element_value (element_value),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.result_value  (result_value),
		.slice_done    (slice_done)
	);

	// 8 ns clock
	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// fold one taken word into the slot model, queue a result if the
	// reduced dimension of that slot is complete
	task automatic fold_word(input word_t v);
		int unsigned  slot;
		result_word_t res;
		slot = inner_pos;
		if (reduced_pos == 0) begin
			// first reduced position always overwrites the slot
			slot_total[slot] = v;
			slot_best[slot]  = '0;
		end else if (op_code == OP_MAX || op_code == OP_ARGMAX) begin
			// strictly greater only, so the first maximum keeps its index
			if (v > slot_total[slot]) begin
				slot_total[slot] = v;
				slot_best[slot]  = reduced_pos[15:0];
			end
		end else begin
			// sum and the spare code, wrapping at the word width
			slot_total[slot] = slot_total[slot] + v;
		end
		if (reduced_pos + 1 >= reduce_len) begin
			res.value = (op_code == OP_ARGMAX) ? word_t'({16'b0, slot_best[slot]})
			                                   : slot_total[slot];
			res.done  = (inner_pos + 1 >= inner_len);
			expected_results.push_back(res);
		end
		inner_pos++;
		if (inner_pos >= inner_len) begin
			inner_pos = 0;
			reduced_pos++;
			if (reduced_pos >= reduce_len)
				reduced_pos = 0;
		end
	endtask

	// one register write, mirrored in the local settings
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
	                         input logic [CFG_DATA_W-1:0] data);
		int unsigned v;
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			REG_OP: begin
				op_code = data[OP_W-1:0];
			end
			REG_REDUCE: begin
				v = data;
				if (v < 1)
					v = 1;
				if (v > REDUCE_MAX_DEF)
					v = REDUCE_MAX_DEF;
				reduce_len = v;
			end
			REG_INNER: begin
				v = data[INNER_FIELD_W-1:0];
				if (v < 1)
					v = 1;
				if (v > INNER_DEPTH_DEF)
					v = INNER_DEPTH_DEF;
				inner_len = v;
			end
			default: begin
			end
		endcase
		// every write, known index or not, opens a new slice
		inner_pos   = 0;
		reduced_pos = 0;
	endtask

	// wait until every word is taken and every result has come back,
	// then give the pipeline time to finish a write-back with no result
	task automatic settle();
		while (pending_words.size() != 0 || element_valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	// element values biased towards extremes and small values that tie
	function automatic word_t pick_word();
		case ($urandom_range(0, 9))
			0:       return 32'sh7FFF_FFFF;
			1:       return 32'sh8000_0000;
			2:       return '0;
			3:       return -32'sd1;
			4, 5:    return word_t'($urandom_range(0, 16)) - 32'sd8;
			default: return word_t'($urandom);
		endcase
	endfunction

	function automatic logic [OP_W-1:0] pick_op();
		case ($urandom_range(0, 3))
			0:       return OP_SUM;
			1:       return OP_MAX;
			2:       return OP_ARGMAX;
			default: return OP_SPARE;
		endcase
	endfunction

	// ---------------------------------------------------------------------
	// driver: offers pending words in bursts, inputs move on the falling edge
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && element_valid && element_ready) begin
			fold_word(element_value);
			took_word = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!element_valid || took_word)) begin
			took_word = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				element_valid <= 1'b0;
			end else if (pending_words.size() != 0) begin
				element_valid <= 1'b1;
				element_value <= pending_words.pop_front();
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					// new burst; a third of the bursts run straight on
					burst_left = $urandom_range(1, 40);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				element_valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------------
	// receiver: alternating ready and stall stretches, plus a long hold-off
	// when the sequence asks for one
	// ---------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_off_request != 0) begin
			hold_off_left    = hold_off_request;
			hold_off_request = 0;
		end
		if (hold_off_left > 0) begin
			hold_off_left--;
			result_ready <= 1'b0;
		end else begin
			if (stretch_left == 0) begin
				stretch_ready = !stretch_ready;
				if (stretch_ready)
					stretch_left = ($urandom_range(0, 3) == 0) ? 80 : $urandom_range(1, 24);
				else
					stretch_left = $urandom_range(1, 6);
			end
			stretch_left--;
			result_ready <= stretch_ready;
		end
	end

	// ---------------------------------------------------------------------
	// monitor: each result taken is checked against the oldest expectation
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		result_word_t want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: value %0d slice_done %0b",
					         result_value, slice_done);
			end else begin
				want = expected_results.pop_front();
				if (result_value !== want.value || slice_done !== want.done) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %0d done %0b, got %0d done %0b",
						         want.value, want.done, result_value, slice_done);
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// sequence
	// ---------------------------------------------------------------------
	initial begin
		logic [OP_W-1:0] op;
		int              rc_raw;
		int              ic_raw;
		int              slice_words;
		int              n;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: sum, single reduced position, single inner slot,
		// so every word comes straight back
		pending_words.push_back(32'sh7FFF_FFFF);
		pending_words.push_back(32'sh8000_0000);
		pending_words.push_back('0);
		pending_words.push_back(-32'sd1);
		settle();

		// max over a single position gives the word itself
		write_reg(REG_OP, OP_MAX);
		pending_words.push_back(32'sh8000_0000);
		pending_words.push_back(32'sh7FFF_FFFF);
		settle();

		// argmax over a single position gives index zero
		write_reg(REG_OP, OP_ARGMAX);
		pending_words.push_back(32'sd5);
		settle();

		// spare code acts as sum, and the sum wraps
		write_reg(REG_OP, OP_SPARE);
		write_reg(REG_REDUCE, 17'd2);
		pending_words.push_back(32'sh7FFF_FFFF);
		pending_words.push_back(32'sd1);
		pending_words.push_back(32'sh8000_0000);
		pending_words.push_back(32'sh8000_0000);
		settle();

		// argmax with ties: the first maximum keeps its index
		write_reg(REG_OP, OP_ARGMAX);
		write_reg(REG_REDUCE, 17'd3);
		write_reg(REG_INNER, 17'd2);
		pending_words.push_back(32'sd7);
		pending_words.push_back(-32'sd5);
		pending_words.push_back(32'sd7);
		pending_words.push_back(-32'sd5);
		pending_words.push_back(32'sd8);
		pending_words.push_back(32'sh8000_0000);
		settle();

		// zero counts saturate up to one
		write_reg(REG_OP, OP_MAX);
		write_reg(REG_REDUCE, 17'd0);
		write_reg(REG_INNER, 17'd0);
		pending_words.push_back(32'sd3);
		pending_words.push_back(-32'sd3);
		settle();

		// a write to the spare index mid-slice restarts the slice
		write_reg(REG_OP, OP_SUM);
		write_reg(REG_REDUCE, 17'd3);
		pending_words.push_back(32'sd1);
		pending_words.push_back(32'sd2);
		settle();
		write_reg(REG_SPARE, CFG_DATA_W'($urandom));
		pending_words.push_back(32'sd10);
		pending_words.push_back(32'sd20);
		pending_words.push_back(32'sd30);
		settle();

		// random settings, mostly whole slices with the odd broken tail
		while (random_words < 350) begin
			op = pick_op();
			case ($urandom_range(0, 9))
				0:       rc_raw = 0;
				1, 2:    rc_raw = $urandom_range(7, 40);
				default: rc_raw = $urandom_range(1, 6);
			endcase
			if (rc_raw > 6) begin
				ic_raw = $urandom_range(1, 4);
			end else begin
				case ($urandom_range(0, 9))
					0:       ic_raw = 0;
					1, 2:    ic_raw = $urandom_range(9, 64);
					default: ic_raw = $urandom_range(1, 8);
				endcase
			end
			// spare bits above the inner and op fields carry noise
			write_reg(REG_INNER, {(CFG_DATA_W-INNER_FIELD_W)'($urandom), INNER_FIELD_W'(ic_raw)});
			write_reg(REG_OP, {(CFG_DATA_W-OP_W)'($urandom), op});
			write_reg(REG_REDUCE, CFG_DATA_W'(rc_raw));
			slice_words = reduce_len * inner_len;
			n = slice_words * $urandom_range(1, (slice_words < 80) ? 80 / slice_words : 1);
			if (slice_words > 1 && $urandom_range(0, 3) == 0)
				n += $urandom_range(1, slice_words - 1);
			repeat (n) pending_words.push_back(pick_word());
			random_words += n;
			settle();
		end

		// widest inner dimension, written past its range so it saturates
		write_reg(REG_OP, pick_op());
		write_reg(REG_REDUCE, 17'd1);
		write_reg(REG_INNER, 17'h1FF);
		repeat (INNER_DEPTH_DEF) pending_words.push_back(pick_word());
		settle();

		// one result per word while the receiver holds off for a long
		// stretch, so the block backs up and stalls its input
		write_reg(REG_OP, OP_SUM);
		write_reg(REG_REDUCE, 17'd1);
		write_reg(REG_INNER, 17'd4);
		hold_off_request = 400;
		repeat (50) pending_words.push_back(pick_word());
		// sender pauses mid-stream until every result is back
		while (pending_words.size() != 0 || element_valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (50) pending_words.push_back(pick_word());
		settle();

		// argmax with the reduce count saturated down to its maximum,
		// a short run of words must complete no result
		write_reg(REG_OP, OP_ARGMAX);
		write_reg(REG_REDUCE, 17'h1FFFF);
		write_reg(REG_INNER, 17'd1);
		repeat (8) pending_words.push_back(word_t'($urandom));
		settle();

		// stray results would show up here
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== reduce_along_dimension.f =====
+incdir+hdl
hdl/rad_pkg.sv
hdl/rad_slot_ram.sv
hdl/reduce_along_dimension.sv
sim/tb_reduce_along_dimension.sv
